### rtl/core/bedl_pkg.sv
// Shared constants, types and state codes for the button debounce and lockout block.
package bedl_pkg;

    // Field and register widths
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int IN_IDX_W    = 2;
    localparam int PINS_W      = 4;
    localparam int CFG_ADDR_W  = 1;

    // Default button count
    localparam int NUM_BUTTONS_DEF = 4;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd15;
    localparam logic [CFG_W-1:0] LOCKOUT_RESET  = 16'd120;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOCKOUT  = 1'b1;

    // Item kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_AGE  = 4'b0010,
        ST_LOCK = 4'b0100,
        ST_DONE = 4'b1000
    } bedl_state_t;

    // Write strobes from the sequencer to the timestamp store
    typedef struct packed {
        logic edge_we;
        logic pend_clr;
        logic acc_we;
    } bedl_store_cmd_t;

endpackage

### rtl/core/bedl_if.sv
// Channel interfaces: input items, result items and register writes.
interface bedl_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [bedl_pkg::IN_IDX_W-1:0] button_index;
    logic [bedl_pkg::TIME_W-1:0]   now_ms;
    logic [bedl_pkg::PINS_W-1:0]   pins_low;

    modport source (output valid, kind, button_index, now_ms, pins_low, input ready);
    modport sink   (input valid, kind, button_index, now_ms, pins_low, output ready);
endinterface

interface bedl_out_if;
    logic                          valid;
    logic                          ready;
    logic                          pressed;
    logic [bedl_pkg::IN_IDX_W-1:0] button;

    modport source (output valid, pressed, button, input ready);
    modport sink   (input valid, pressed, button, output ready);
endinterface

interface bedl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bedl_pkg::CFG_ADDR_W-1:0] index;
    logic [bedl_pkg::CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/bedl_cmp.sv
// Shared wrapping time compare: (a - b) mod 2^32 against a limit.
module bedl_cmp
(
    input  logic [bedl_pkg::TIME_W-1:0] a,
    input  logic [bedl_pkg::TIME_W-1:0] b,
    input  logic [bedl_pkg::CFG_W-1:0]  limit,
    output logic                        ge
);

    logic [bedl_pkg::TIME_W-1:0] diff;

    // Take the wrapped age and check it against the limit
    always_comb
    begin
        diff = a - b;
        ge   = (diff >= bedl_pkg::TIME_W'(limit));
    end

endmodule

### rtl/core/bedl_store.sv
// Per-button edge timestamps, acceptance timestamps and pending marks.
module bedl_store
#(
    parameter int NUM_BUTTONS = bedl_pkg::NUM_BUTTONS_DEF,
    parameter int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  bedl_pkg::bedl_store_cmd_t       cmd,
    input  logic [IDX_W-1:0]                edge_idx,
    input  logic [IDX_W-1:0]                scan_idx,
    input  logic [bedl_pkg::TIME_W-1:0]     wr_time,
    output logic [NUM_BUTTONS-1:0]          pending,
    output logic [bedl_pkg::TIME_W-1:0]     edge_time,
    output logic [bedl_pkg::TIME_W-1:0]     accept_time
);

    logic [bedl_pkg::TIME_W-1:0] edge_time_reg   [NUM_BUTTONS];
    logic [bedl_pkg::TIME_W-1:0] accept_time_reg [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]      pending_reg;

    // Record edge times, clear or set pending marks, stamp acceptances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                edge_time_reg[i]   <= '0;
                accept_time_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.edge_we)
            begin
                edge_time_reg[edge_idx] <= wr_time;
                pending_reg[edge_idx]   <= 1'b1;
            end
            if (cmd.pend_clr)
            begin
                pending_reg[scan_idx] <= 1'b0;
            end
            if (cmd.acc_we)
            begin
                accept_time_reg[scan_idx] <= wr_time;
            end
        end
    end

    // Present the button under scan
    assign pending     = pending_reg;
    assign edge_time   = edge_time_reg[scan_idx];
    assign accept_time = accept_time_reg[scan_idx];

endmodule

### rtl/core/bedl_seq.sv
// Scan sequencer: takes items, walks the buttons through the shared compare, holds the result.
module bedl_seq
#(
    parameter int NUM_BUTTONS = bedl_pkg::NUM_BUTTONS_DEF,
    parameter int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input item
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [bedl_pkg::IN_IDX_W-1:0]   button_index,
    input  logic [bedl_pkg::TIME_W-1:0]     now_ms,
    input  logic [bedl_pkg::PINS_W-1:0]     pins_low,
    // result item
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            pressed,
    output logic [bedl_pkg::IN_IDX_W-1:0]   button,
    // registers
    input  logic [bedl_pkg::CFG_W-1:0]      debounce_time,
    input  logic [bedl_pkg::CFG_W-1:0]      lockout_time,
    // store side
    output bedl_pkg::bedl_store_cmd_t       cmd,
    output logic [IDX_W-1:0]                edge_idx,
    output logic [IDX_W-1:0]                scan_idx,
    output logic [bedl_pkg::TIME_W-1:0]     wr_time,
    input  logic [NUM_BUTTONS-1:0]          pending,
    input  logic [bedl_pkg::TIME_W-1:0]     edge_time,
    input  logic [bedl_pkg::TIME_W-1:0]     accept_time,
    // compare unit side
    output logic [bedl_pkg::TIME_W-1:0]     cmp_a,
    output logic [bedl_pkg::TIME_W-1:0]     cmp_b,
    output logic [bedl_pkg::CFG_W-1:0]      cmp_limit,
    input  logic                            cmp_ge
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

    bedl_pkg::bedl_state_t          state_reg, state_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [bedl_pkg::TIME_W-1:0]    now_reg, now_next;
    logic [bedl_pkg::PINS_W-1:0]    pins_reg, pins_next;
    logic                           res_pressed_reg, res_pressed_next;
    logic [bedl_pkg::IN_IDX_W-1:0]  res_button_reg, res_button_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           pressed_reg, pressed_next;
    logic [bedl_pkg::IN_IDX_W-1:0]  button_reg, button_next;

    logic                           take;
    logic                           edge_in_range;
    logic [3:0]                     idx_wide;
    logic                           pin_low;

    // Decode the scanned button and its pin level
    always_comb
    begin
        take          = in_valid && in_ready;
        edge_in_range = (32'(button_index) < NUM_BUTTONS);
        idx_wide      = 4'(idx_reg);
        pin_low       = (idx_wide < 4'(bedl_pkg::PINS_W)) && pins_reg[idx_wide[1:0]];
    end

    // Sequence the scan
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        now_next         = now_reg;
        pins_next        = pins_reg;
        res_pressed_next = res_pressed_reg;
        res_button_next  = res_button_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        pressed_next     = pressed_reg;
        button_next      = button_reg;
        cmd              = '0;
        edge_idx         = IDX_W'(button_index);
        wr_time          = now_reg;

        unique case (state_reg)
            bedl_pkg::ST_IDLE:
            begin
                wr_time = now_ms;
                if (take)
                begin
                    if (kind == bedl_pkg::KIND_EDGE)
                    begin
                        // Keep the earlier timestamp while already pending
                        if (edge_in_range)
                        begin
                            if (!pending[edge_idx])
                            begin
                                cmd.edge_we = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        now_next         = now_ms;
                        pins_next        = pins_low;
                        idx_next         = '0;
                        res_pressed_next = 1'b0;
                        res_button_next  = '0;
                        state_next       = bedl_pkg::ST_AGE;
                    end
                end
            end

            bedl_pkg::ST_AGE:
            begin
                if (pending[idx_reg] && cmp_ge)
                begin
                    cmd.pend_clr = 1'b1;
                end
                if (pending[idx_reg] && cmp_ge && pin_low)
                begin
                    state_next = bedl_pkg::ST_LOCK;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = bedl_pkg::ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            bedl_pkg::ST_LOCK:
            begin
                if (cmp_ge)
                begin
                    cmd.acc_we       = 1'b1;
                    res_pressed_next = 1'b1;
                    res_button_next  = idx_wide[1:0];
                    state_next       = bedl_pkg::ST_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = bedl_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = bedl_pkg::ST_AGE;
                end
            end

            bedl_pkg::ST_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    pressed_next   = res_pressed_reg;
                    button_next    = res_button_reg;
                    state_next     = bedl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bedl_pkg::ST_IDLE;
            end
        endcase
    end

    // Route the scanned button into the shared compare
    always_comb
    begin
        cmp_a = now_reg;
        if (state_reg == bedl_pkg::ST_LOCK)
        begin
            cmp_b     = accept_time;
            cmp_limit = lockout_time;
        end
        else
        begin
            cmp_b     = edge_time;
            cmp_limit = debounce_time;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bedl_pkg::ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        pins_reg        <= pins_next;
        res_pressed_reg <= res_pressed_next;
        res_button_reg  <= res_button_next;
        pressed_reg     <= pressed_next;
        button_reg      <= button_next;
    end

    assign in_ready  = (state_reg == bedl_pkg::ST_IDLE);
    assign scan_idx  = idx_reg;
    assign out_valid = out_valid_reg;
    assign pressed   = pressed_reg;
    assign button    = button_reg;

endmodule

### rtl/core/button_edge_debounce_lockout.sv
// Top level of the button debounce and lockout qualifier.
//
// Channels: "item" takes edge beats (kind 0: a falling edge on button_index at
// now_ms) and poll beats (kind 1: the time and the pin levels). "result" gives one
// beat per poll: pressed and the accepted button, or pressed 0 and button 0.
// "cfg" writes debounce_time (index 0) and lockout_time (index 1); it is always
// ready. Users must write it only while the block is idle; nothing enforces it.
//
// An edge beat is taken and the block stays ready. A poll walks the buttons one
// at a time through a single wrapping subtract and compare unit: each button gets
// an age check in ST_AGE, an aged button whose pin reads low also gets a lockout
// check in ST_LOCK, and the scan ends at the first button that passes it; ST_DONE
// then loads the output register. The block is ready again in the cycle the
// result turns valid and takes no item while a poll is scanning.
//
// Reset clears all timestamps and pending marks and loads the register defaults.
// A stalled result sits in the output register; the block still accepts items,
// and a following poll waits at its end until the output register frees up.
module button_edge_debounce_lockout
#(
    parameter int NUM_BUTTONS = bedl_pkg::NUM_BUTTONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    bedl_in_if.sink     item,
    bedl_out_if.source  result,
    bedl_cfg_if.sink    cfg
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic [bedl_pkg::CFG_W-1:0]  debounce_reg, debounce_next;
    logic [bedl_pkg::CFG_W-1:0]  lockout_reg, lockout_next;

    bedl_pkg::bedl_store_cmd_t   cmd;
    logic [IDX_W-1:0]            edge_idx;
    logic [IDX_W-1:0]            scan_idx;
    logic [bedl_pkg::TIME_W-1:0] wr_time;
    logic [NUM_BUTTONS-1:0]      pending;
    logic [bedl_pkg::TIME_W-1:0] edge_time;
    logic [bedl_pkg::TIME_W-1:0] accept_time;
    logic [bedl_pkg::TIME_W-1:0] cmp_a;
    logic [bedl_pkg::TIME_W-1:0] cmp_b;
    logic [bedl_pkg::CFG_W-1:0]  cmp_limit;
    logic                        cmp_ge;

    // Register writes
    always_comb
    begin
        debounce_next = debounce_reg;
        lockout_next  = lockout_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                bedl_pkg::REG_DEBOUNCE: debounce_next = cfg.data;
                bedl_pkg::REG_LOCKOUT:  lockout_next  = cfg.data;
                default:                debounce_next = debounce_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= bedl_pkg::DEBOUNCE_RESET;
            lockout_reg  <= bedl_pkg::LOCKOUT_RESET;
        end
        else
        begin
            debounce_reg <= debounce_next;
            lockout_reg  <= lockout_next;
        end
    end

    assign cfg.ready = 1'b1;

    // Scan sequencer
    bedl_seq #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .IDX_W       (IDX_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (item.valid),
        .in_ready      (item.ready),
        .kind          (item.kind),
        .button_index  (item.button_index),
        .now_ms        (item.now_ms),
        .pins_low      (item.pins_low),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .pressed       (result.pressed),
        .button        (result.button),
        .debounce_time (debounce_reg),
        .lockout_time  (lockout_reg),
        .cmd           (cmd),
        .edge_idx      (edge_idx),
        .scan_idx      (scan_idx),
        .wr_time       (wr_time),
        .pending       (pending),
        .edge_time     (edge_time),
        .accept_time   (accept_time),
        .cmp_a         (cmp_a),
        .cmp_b         (cmp_b),
        .cmp_limit     (cmp_limit),
        .cmp_ge        (cmp_ge)
    );

    // Timestamp store
    bedl_store #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .edge_idx    (edge_idx),
        .scan_idx    (scan_idx),
        .wr_time     (wr_time),
        .pending     (pending),
        .edge_time   (edge_time),
        .accept_time (accept_time)
    );

    // Shared wrapping compare
    bedl_cmp u_cmp (
        .a     (cmp_a),
        .b     (cmp_b),
        .limit (cmp_limit),
        .ge    (cmp_ge)
    );

endmodule
